FILE: sv/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
`default_nettype none

package lkvc_pkg;

   // payload widths
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // default number of slots and capacity after reset
   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // read value returned on a miss
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // transaction kinds
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic             clear;    // drop every entry
      logic             capture;  // latch the key compare result
      logic             shift;    // move entries one place toward the tail
      logic [KEY_W-1:0] key;      // key loaded into the head cell
      logic [VAL_W-1:0] value;    // value loaded into the head cell
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: sv/lru_key_value_cache.sv
// top level of the lru key-value cache: controller, cell chain and output register
// a get result is registered at the end of the lookup, reduce and commit steps
// a new transaction is taken only in the idle state, once the compare, reduce and shift
//   steps of the cell chain are done; a get waits longer while the previous result is still stalled
// reset: synchronous, clears all entries and the fill count, capacity returns to 16;
//   a capacity write clears all entries in the same cycle
`default_nettype none

module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_kind,
   input  wire  signed [lkvc_pkg::KEY_W-1:0]   req_key,
   input  wire  signed [lkvc_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_hit,
   output logic signed [lkvc_pkg::VAL_W-1:0]   rsp_read_value,
   input  wire                                 csr_wr_en,
   input  wire  [lkvc_pkg::CAP_W-1:0]          csr_wr_data
);

   localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (lkvc_pkg::CAP_W > CNT_W) ? lkvc_pkg::CAP_W : CNT_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_LOOKUP = 4'b0010,
      S_REDUCE = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic                         op_kind_ff;
   logic [lkvc_pkg::KEY_W-1:0]   op_key_ff;
   logic [lkvc_pkg::VAL_W-1:0]   op_value_ff;
   logic [lkvc_pkg::CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_hit_ff;
   logic [lkvc_pkg::VAL_W-1:0]   rsp_value_ff;

   logic                         accept;
   logic                         commit_fire;
   logic                         get_fire;
   logic [CMP_W-1:0]             cap_ext;
   logic [CMP_W-1:0]             cap_eff;
   logic                         full;
   logic [POS_W-1:0]             limit;
   lkvc_pkg::cell_cmd_type       cmd;

   logic                         hit;
   logic [POS_W-1:0]             hit_pos;
   logic [lkvc_pkg::VAL_W-1:0]   hit_value;

   logic [lkvc_pkg::KEY_W-1:0]   cell_key   [ENTRIES];
   logic [lkvc_pkg::VAL_W-1:0]   cell_value [ENTRIES];
   logic [ENTRIES-1:0]           cell_valid;
   logic [ENTRIES-1:0]           cell_match;

   // input handshake
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // commit waits only when a get result cannot be placed in the output register
   assign commit_fire = (state_ff == S_COMMIT) &&
                        !((op_kind_ff == lkvc_pkg::KIND_GET) && rsp_valid_ff && rsp_stall);
   assign get_fire    = commit_fire && (op_kind_ff == lkvc_pkg::KIND_GET);

   // capacity in force, clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end
   assign full = (CMP_W'(count_ff) >= cap_eff);

   // last chain position that shifts: hit slot, first free slot or the oldest slot
   always_comb begin
      if (hit) begin
         limit = hit_pos;
      end else if (full) begin
         limit = POS_W'(count_ff - 1'b1);
      end else begin
         limit = POS_W'(count_ff);
      end
   end

   // command broadcast to the cells
   always_comb begin
      cmd.clear   = csr_wr_en;
      cmd.capture = (state_ff == S_LOOKUP);
      cmd.shift   = commit_fire && ((op_kind_ff == lkvc_pkg::KIND_PUT) || hit);
      cmd.key     = op_key_ff;
      cmd.value   = (op_kind_ff == lkvc_pkg::KIND_PUT) ? op_value_ff : hit_value;
   end

   // state machine
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // transaction being worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         op_kind_ff  <= req_kind;
         op_key_ff   <= req_key;
         op_value_ff <= req_value;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // fill count grows on a put miss while below capacity and clears on a capacity write
   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = '0;
      end else if (commit_fire && (op_kind_ff == lkvc_pkg::KIND_PUT) && !hit && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // cell chain, head cell loads the transaction's entry
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [lkvc_pkg::KEY_W-1:0] left_key;
      logic [lkvc_pkg::VAL_W-1:0] left_value;
      logic                       left_valid;

      if (i == 0) begin : g_head
         assign left_key   = cmd.key;
         assign left_value = cmd.value;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      lkvc_cell #(
         .IDX   (i),
         .POS_W (POS_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .limit      (limit),
         .left_key   (left_key),
         .left_value (left_value),
         .left_valid (left_valid),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .match      (cell_match[i])
      );
   end

   // hit reduction
   lkvc_reduce #(
      .ENTRIES (ENTRIES),
      .POS_W   (POS_W)
   ) u_reduce (
      .clock     (clock),
      .capture   (state_ff == S_REDUCE),
      .match     (cell_match),
      .values    (cell_value),
      .hit       (hit),
      .hit_pos   (hit_pos),
      .hit_value (hit_value)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (get_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (get_fire) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= hit ? hit_value : lkvc_pkg::MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // fill count never exceeds the capacity in force
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= cap_eff)
      else $error("fill count above capacity");

   // fill count matches the number of valid cells
   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("fill count out of step with valid cells");

   // a new result comes only out of the commit step of a get
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_COMMIT) &&
                              ($past(op_kind_ff) == lkvc_pkg::KIND_GET))
      else $error("result without a committed get");

   // fill count only steps up by one outside a capacity write
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(csr_wr_en) && (count_ff != $past(count_ff)))
         |-> (int'(count_ff) == int'($past(count_ff)) + 1))
      else $error("fill count changed by more than one");

endmodule

`default_nettype wire

FILE: sv/lkvc_cell.sv
// one slot of the recency-ordered chain: key, value, valid and compare result
`default_nettype none

module lkvc_cell #(
   parameter int IDX   = 0,
   parameter int POS_W = 4
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  lkvc_pkg::cell_cmd_type     cmd,
   input  wire  [POS_W-1:0]                 limit,
   input  wire  [lkvc_pkg::KEY_W-1:0]       left_key,
   input  wire  [lkvc_pkg::VAL_W-1:0]       left_value,
   input  wire                              left_valid,
   output logic [lkvc_pkg::KEY_W-1:0]       key,
   output logic [lkvc_pkg::VAL_W-1:0]       value,
   output logic                             valid,
   output logic                             match
);

   logic [lkvc_pkg::KEY_W-1:0] key_ff;
   logic [lkvc_pkg::VAL_W-1:0] value_ff;
   logic                       valid_ff;
   logic                       match_ff;
   logic                       take;

   // this cell takes its left neighbor's entry when it lies at or before the limit
   assign take = cmd.shift && (POS_W'(IDX) <= limit);

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.clear) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= left_valid;
      end
   end

   // entry contents
   always_ff @(posedge clock) begin
      if (take) begin
         key_ff   <= left_key;
         value_ff <= left_value;
      end
   end

   // key compare result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         match_ff <= valid_ff && (key_ff == cmd.key);
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

FILE: sv/lkvc_reduce.sv
// folds the per-cell compare results into hit flag, hit position and hit value
`default_nettype none

module lkvc_reduce #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int POS_W   = 4
) (
   input  wire                          clock,
   input  wire                          capture,
   input  wire  [ENTRIES-1:0]           match,
   input  wire  [lkvc_pkg::VAL_W-1:0]   values [ENTRIES],
   output logic                         hit,
   output logic [POS_W-1:0]             hit_pos,
   output logic [lkvc_pkg::VAL_W-1:0]   hit_value
);

   logic                       hit_ff;
   logic [POS_W-1:0]           pos_ff;
   logic [POS_W-1:0]           pos_in;
   logic [lkvc_pkg::VAL_W-1:0] value_ff;
   logic [lkvc_pkg::VAL_W-1:0] value_in;

   // at most one cell matches, so an or over masked entries picks it
   always_comb begin
      pos_in   = '0;
      value_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         pos_in   = pos_in | ({POS_W{match[i]}} & POS_W'(i));
         value_in = value_in | ({lkvc_pkg::VAL_W{match[i]}} & values[i]);
      end
   end

   // registered result
   always_ff @(posedge clock) begin
      if (capture) begin
         hit_ff   <= |match;
         pos_ff   <= pos_in;
         value_ff <= value_in;
      end
   end

   assign hit       = hit_ff;
   assign hit_pos   = pos_ff;
   assign hit_value = value_ff;

endmodule

`default_nettype wire
